// ===== design/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
// No dependencies; every other design file imports this package.
package bfa_pkg;

  localparam int unsigned MAX_FRAMES = 8192;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned MAP_AW     = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned FRAME_W    = 13;
  localparam int unsigned COUNT_W    = 14;
  localparam int unsigned CFG_W      = 14;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RESET    = 14'd8192;
  localparam logic [CFG_W-1:0] RESERVED_RESET = 14'd512;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NONE  = 2'd3
  } bfa_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_OOM = 2'd1,
    STAT_BAD = 2'd2
  } bfa_status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_INIT,
    FSM_SCAN,
    FSM_FREE,
    FSM_DONE
  } bfa_state_e;

  typedef struct packed {
    bfa_cmd_e           cmd;
    logic [FRAME_W-1:0] frame_index;
  } bfa_in_t;

  typedef struct packed {
    bfa_status_e        status;
    logic [FRAME_W-1:0] alloc_index;
    logic [COUNT_W-1:0] free_frames;
  } bfa_out_t;

  typedef struct packed {
    logic [COUNT_W-1:0] eff_total;
    logic [COUNT_W-1:0] eff_reserve;
  } bfa_cfg_t;

  typedef struct packed {
    logic                 any_free;
    logic [BIT_W-1:0]     free_bit;
    logic                 bit_set;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic [WORD_BITS-1:0] init_word;
  } bfa_word_res_t;

endpackage

// ===== design/bitmap_frame_allocator.sv =====
// Top level of the bitmap frame allocator: configuration registers, clamping, engine.
// Depends on bfa_pkg and bfa_engine.
//
// Usage: one command word enters on in_valid_i/in_stall_o (init map, allocate, free)
// and exactly one result word leaves on out_valid_o/out_stall_i with the status,
// the allocated frame and the free-frame count after the command.
// The usage map is a 256 x 32 memory with a registered read port, walked by a
// single word unit one map word per cycle.
// Path from the accepting edge to out_valid_o high: unused codes and out-of-range
// frees go straight to the result step, other frees first update their map word,
// allocate has one map word checked per cycle up to the first word with a clear bit
// (or the last word), init has one map word written per cycle.
// One command is in work at a time; in_stall_o is high until its result has
// moved into the output register, and the next command may enter while that
// result still waits there.
// After reset the block sweeps all 256 map words clear with in_stall_o
// high; configuration writes are taken during that sweep.
// A stalled receiver holds the result register; the sequencer then waits with
// the next result and keeps in_stall_o high.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) must be written only while idle; the block does not enforce this.
module bitmap_frame_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bfa_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bfa_pkg::bfa_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bfa_pkg::bfa_out_t               out_data_o
);
  import bfa_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAMES);

  logic [CFG_W-1:0] total_q, total_d;
  logic [CFG_W-1:0] reserved_q, reserved_d;
  bfa_cfg_t         cfg;

  always_comb begin
    total_d    = total_q;
    reserved_d = reserved_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL:    total_d    = cfg_wdata_i;
        CFG_RESERVED: reserved_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= TOTAL_RESET;
      reserved_q <= RESERVED_RESET;
    end else begin
      total_q    <= total_d;
      reserved_q <= reserved_d;
    end
  end

  assign cfg.eff_total   = (total_q > MAX_COUNT) ? MAX_COUNT : total_q;
  assign cfg.eff_reserve = (reserved_q > cfg.eff_total) ? cfg.eff_total : reserved_q;

  bfa_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("command accepted while another is in work");

  a_index_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STAT_OK) |-> (out_data_o.alloc_index == '0))
    else $error("frame index reported on a failed command");

  a_free_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !cfg_we_i) |-> (out_data_o.free_frames <= cfg.eff_total))
    else $error("free frame count above frame total");

endmodule

// ===== design/bfa_word_unit.sv =====
// Shared word unit: lowest-free-bit search, bit set/clear/test, init fill pattern.
// Depends on bfa_pkg.
module bfa_word_unit (
  input  logic [bfa_pkg::WORD_BITS-1:0] word_i,
  input  logic [bfa_pkg::BIT_W-1:0]     bit_i,
  input  logic [bfa_pkg::MAP_AW-1:0]    base_i,
  input  logic [bfa_pkg::COUNT_W-1:0]   reserve_i,
  output bfa_pkg::bfa_word_res_t        res_o
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] avail;
  logic [BIT_W-1:0]     low_bit;
  logic [COUNT_W-1:0]   lo_frame;
  logic [COUNT_W-1:0]   hi_frame;
  logic [COUNT_W-1:0]   fill_len;
  logic [WORD_BITS-1:0] fill_word;

  assign avail = ~word_i;

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        low_bit = BIT_W'(i);
      end
    end
  end

  assign lo_frame = COUNT_W'({base_i, {BIT_W{1'b0}}});
  assign hi_frame = lo_frame + COUNT_W'(WORD_BITS);
  assign fill_len = reserve_i - lo_frame;

  always_comb begin
    if (reserve_i >= hi_frame) begin
      fill_word = '1;
    end else if (reserve_i <= lo_frame) begin
      fill_word = '0;
    end else begin
      fill_word = ~({WORD_BITS{1'b1}} << fill_len[BIT_W-1:0]);
    end
  end

  assign res_o.any_free  = |avail;
  assign res_o.free_bit  = low_bit;
  assign res_o.bit_set   = word_i[bit_i];
  assign res_o.set_word  = word_i | (WORD_BITS'(1) << low_bit);
  assign res_o.clr_word  = word_i & ~(WORD_BITS'(1) << bit_i);
  assign res_o.init_word = fill_word;

endmodule

// ===== design/bfa_engine.sv =====
// Command sequencer with the usage map memory, used-frame count and result register.
// Depends on bfa_pkg and bfa_word_unit.
module bfa_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfa_pkg::bfa_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfa_pkg::bfa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfa_pkg::bfa_out_t out_data_o
);
  import bfa_pkg::*;

  localparam logic [MAP_AW-1:0] LAST_WORD = MAP_AW'(MAP_WORDS - 1);

  bfa_state_e           state_q, state_d;
  logic                 clr_q, clr_d;
  logic [MAP_AW-1:0]    wcnt_q, wcnt_d;
  logic [FRAME_W-1:0]   fidx_q, fidx_d;
  logic [COUNT_W-1:0]   used_q, used_d;
  bfa_status_e          rstat_q, rstat_d;
  logic [FRAME_W-1:0]   ridx_q, ridx_d;
  logic                 out_valid_q, out_valid_d;
  bfa_out_t             out_q, out_d;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [MAP_AW-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [MAP_AW-1:0]    mem_raddr;

  logic [COUNT_W-1:0]   reserve;
  logic [FRAME_W-1:0]   found_frame;
  logic                 accept;
  logic                 load_out;
  logic [COUNT_W-1:0]   free_cnt;
  bfa_word_res_t        wres;

  assign accept      = (state_q == FSM_IDLE) && in_valid_i;
  assign load_out    = (state_q == FSM_DONE) && (!out_valid_q || !out_stall_i);
  assign reserve     = clr_q ? '0 : cfg_i.eff_reserve;
  assign found_frame = {wcnt_q, wres.free_bit};
  assign free_cnt    = (used_q >= cfg_i.eff_total) ? '0 : cfg_i.eff_total - used_q;

  bfa_word_unit u_word (
    .word_i    (rdata_q),
    .bit_i     (fidx_q[BIT_W-1:0]),
    .base_i    (wcnt_q),
    .reserve_i (reserve),
    .res_o     (wres)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= map_mem[mem_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.cmd)
            CMD_INIT:  state_d = FSM_INIT;
            CMD_ALLOC: state_d = FSM_SCAN;
            CMD_FREE: begin
              if ({1'b0, in_data_i.frame_index} >= cfg_i.eff_total) begin
                state_d = FSM_DONE;
              end else begin
                state_d = FSM_FREE;
              end
            end
            default:   state_d = FSM_DONE;
          endcase
        end
      end
      FSM_INIT: begin
        if (wcnt_q == LAST_WORD) begin
          state_d = clr_q ? FSM_IDLE : FSM_DONE;
        end
      end
      FSM_SCAN: begin
        if (wres.any_free || (wcnt_q == LAST_WORD)) begin
          state_d = FSM_DONE;
        end
      end
      FSM_FREE: state_d = FSM_DONE;
      FSM_DONE: begin
        if (load_out) begin
          state_d = FSM_IDLE;
        end
      end
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    clr_d     = clr_q;
    wcnt_d    = wcnt_q;
    fidx_d    = fidx_q;
    used_d    = used_q;
    rstat_d   = rstat_q;
    ridx_d    = ridx_q;
    mem_we    = 1'b0;
    mem_waddr = wcnt_q;
    mem_wdata = wres.init_word;
    mem_raddr = wcnt_q + MAP_AW'(1);
    out_d     = out_q;
    unique case (state_q)
      FSM_IDLE: begin
        mem_raddr = (in_data_i.cmd == CMD_FREE) ?
                    in_data_i.frame_index[FRAME_W-1:BIT_W] : '0;
        if (accept) begin
          wcnt_d  = '0;
          fidx_d  = in_data_i.frame_index;
          ridx_d  = '0;
          rstat_d = (in_data_i.cmd == CMD_INIT || in_data_i.cmd == CMD_ALLOC) ?
                    STAT_OK : STAT_BAD;
        end
      end
      FSM_INIT: begin
        mem_we = 1'b1;
        wcnt_d = wcnt_q + MAP_AW'(1);
        if (wcnt_q == LAST_WORD) begin
          used_d = reserve;
          clr_d  = 1'b0;
        end
      end
      FSM_SCAN: begin
        if (wres.any_free) begin
          if ({1'b0, found_frame} >= cfg_i.eff_total) begin
            rstat_d = STAT_OOM;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = wres.set_word;
            used_d    = used_q + COUNT_W'(1);
            ridx_d    = found_frame;
          end
        end else if (wcnt_q == LAST_WORD) begin
          rstat_d = STAT_OOM;
        end else begin
          wcnt_d = wcnt_q + MAP_AW'(1);
        end
      end
      FSM_FREE: begin
        mem_waddr = fidx_q[FRAME_W-1:BIT_W];
        mem_wdata = wres.clr_word;
        if (wres.bit_set) begin
          mem_we  = 1'b1;
          rstat_d = STAT_OK;
          if (used_q != '0) begin
            used_d = used_q - COUNT_W'(1);
          end
        end else begin
          rstat_d = STAT_BAD;
        end
      end
      FSM_DONE: begin
        if (load_out) begin
          out_d.status      = rstat_q;
          out_d.alloc_index = ridx_q;
          out_d.free_frames = free_cnt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_INIT;
      clr_q       <= 1'b1;
      wcnt_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wcnt_q      <= wcnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fidx_q  <= fidx_d;
    rstat_q <= rstat_d;
    ridx_q  <= ridx_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/bfa_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the bitmap frame allocator: tracks config writes, predicts
// the result word of every accepted command and compares it. Depends on bfa_pkg.
module bfa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfa_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  bfa_pkg::bfa_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  bfa_pkg::bfa_out_t             out_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   results_owed_o
);
  import bfa_pkg::*;

  logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
  logic [COUNT_W-1:0]   frames_in_use;
  logic [CFG_W-1:0]     total_reg;
  logic [CFG_W-1:0]     reserve_reg;
  bfa_out_t             cmd_results_q [$];

  initial begin
    fail_count_o   = 0;
    results_owed_o = 0;
  end

  function automatic logic [COUNT_W-1:0] frames_managed();
    return (total_reg > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES) : total_reg;
  endfunction

  function automatic logic [COUNT_W-1:0] frames_left();
    logic [COUNT_W-1:0] t;
    t = frames_managed();
    return (frames_in_use >= t) ? '0 : t - frames_in_use;
  endfunction

  function automatic void mark_reserved();
    logic [COUNT_W-1:0] t;
    logic [COUNT_W-1:0] r;
    t = frames_managed();
    r = (reserve_reg > t) ? t : reserve_reg;
    foreach (frame_map[w]) frame_map[w] = '0;
    for (int unsigned i = 0; i < r; i++) frame_map[i / WORD_BITS][i % WORD_BITS] = 1'b1;
    frames_in_use = r;
  endfunction

  function automatic bit take_lowest_frame(output logic [FRAME_W-1:0] idx);
    int unsigned f;
    idx = '0;
    for (int unsigned w = 0; w < MAP_WORDS; w++) begin
      if (~frame_map[w] != '0) begin
        for (int unsigned b = 0; b < WORD_BITS; b++) begin
          if (!frame_map[w][b]) begin
            f = w * WORD_BITS + b;
            if (f >= frames_managed()) return 1'b0;
            frame_map[w][b] = 1'b1;
            frames_in_use++;
            idx = FRAME_W'(f);
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic bit release_frame(input logic [FRAME_W-1:0] f);
    if (f >= frames_managed()) return 1'b0;
    if (!frame_map[f / WORD_BITS][f % WORD_BITS]) return 1'b0;
    frame_map[f / WORD_BITS][f % WORD_BITS] = 1'b0;
    if (frames_in_use > 0) frames_in_use--;
    return 1'b1;
  endfunction

  function automatic bfa_out_t predict_result(input bfa_in_t w);
    bfa_out_t           r;
    logic [FRAME_W-1:0] idx;
    r.status      = STAT_OK;
    r.alloc_index = '0;
    case (w.cmd)
      CMD_INIT: mark_reserved();
      CMD_ALLOC: begin
        if (take_lowest_frame(idx)) r.alloc_index = idx;
        else r.status = STAT_OOM;
      end
      CMD_FREE: begin
        if (!release_frame(w.frame_index)) r.status = STAT_BAD;
      end
      default: r.status = STAT_BAD;
    endcase
    r.free_frames = frames_left();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bfa_out_t want;
    if (!rst_ni) begin
      foreach (frame_map[w]) frame_map[w] = '0;
      frames_in_use = '0;
      total_reg     = TOTAL_RESET;
      reserve_reg   = RESERVED_RESET;
      cmd_results_q.delete();
      results_owed_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (cmd_results_q.size() == 0) begin
          $error("result word with no command outstanding");
          fail_count_o++;
        end else begin
          want = cmd_results_q.pop_front();
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data_i.status);
            fail_count_o++;
          end
          if (out_data_i.alloc_index !== want.alloc_index) begin
            $error("alloc_index: expected %0d, actual %0d",
                   want.alloc_index, out_data_i.alloc_index);
            fail_count_o++;
          end
          if (out_data_i.free_frames !== want.free_frames) begin
            $error("free_frames: expected %0d, actual %0d",
                   want.free_frames, out_data_i.free_frames);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOTAL:    total_reg   = cfg_wdata_i;
          CFG_RESERVED: reserve_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) cmd_results_q.push_back(predict_result(in_data_i));
      results_owed_o = cmd_results_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for bitmap_frame_allocator: clock, reset, config and command
// stimulus, receiver stalls and verdict. Depends on bfa_pkg, bfa_checker and bitmap_frame_allocator.
module tb_top;
  import bfa_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned RANDOM_WORDS = 1950;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_TOTAL;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  bfa_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  bfa_out_t             out_data_o;

  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned words_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count;
  int unsigned results_owed;

  bitmap_frame_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  bfa_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_i     (out_data_o),
    .fail_count_o   (fail_count),
    .results_owed_o (results_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(input bfa_cmd_e c, input logic [FRAME_W-1:0] fi);
    bfa_in_t w;
    w.cmd         = c;
    w.frame_index = fi;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] total, input logic [CFG_W-1:0] reserve);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TOTAL;
    cfg_wdata_i <= total;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_RESERVED;
    cfg_wdata_i <= reserve;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned pick;
    int unsigned total_pick;
    int unsigned reserve_pick;
    int unsigned managed;
    int unsigned high_water;
    int unsigned span;
    int unsigned phase;
    int unsigned target;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // commands on the map as reset, before any init
    send_word(CMD_ALLOC, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, '0);
    send_word(CMD_FREE, '0);
    send_word(CMD_FREE, FRAME_W'(MAX_FRAMES - 1));
    send_word(CMD_NONE, FRAME_W'(MAX_FRAMES - 1));
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, 13'd511);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, FRAME_W'(MAX_FRAMES - 1));
    // lower the total below frames in use
    set_limits(14'd100, 14'd512);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, 13'd512);
    send_word(CMD_FREE, 13'd50);
    // total above the map size, reserve covering all of it
    set_limits(14'd16383, 14'd16383);
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, FRAME_W'(MAX_FRAMES - 1));
    send_word(CMD_ALLOC, '0);
    set_limits(14'd0, 14'd0);
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, '0);
    set_limits(14'd8192, 14'd0);
    send_word(CMD_INIT, '0);
    send_word(CMD_ALLOC, '0);
    send_word(CMD_FREE, '0);

    phase  = 0;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 60) total_pick = $urandom_range(600, 1);
      else if (pick < 85) total_pick = $urandom_range(2048, 600);
      else if (pick < 93) total_pick = $urandom_range(MAX_FRAMES, 2048);
      else if (pick < 97) total_pick = $urandom_range(16383, MAX_FRAMES + 1);
      else total_pick = 0;
      pick = $urandom_range(99);
      if (pick < 70) reserve_pick = $urandom_range(total_pick / 2, 0);
      else if (pick < 88) reserve_pick = $urandom_range(total_pick, 0);
      else reserve_pick = $urandom_range(16383, 0);
      set_limits(CFG_W'(total_pick), CFG_W'(reserve_pick));

      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 63; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 63; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase
      phase++;

      managed    = (total_pick > MAX_FRAMES) ? MAX_FRAMES : total_pick;
      high_water = (reserve_pick > managed) ? managed : reserve_pick;
      // keep the old map now and then so frames above a lowered total remain
      if ($urandom_range(9) != 0) send_word(CMD_INIT, FRAME_W'($urandom_range(MAX_FRAMES - 1)));

      span = $urandom_range(80, 30);
      repeat (span) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          send_word(CMD_ALLOC, FRAME_W'($urandom_range(MAX_FRAMES - 1)));
          if (high_water < MAX_FRAMES - 1) high_water++;
        end else if (pick < 85) begin
          send_word(CMD_FREE, FRAME_W'($urandom_range(high_water, 0)));
        end else if (pick < 92) begin
          send_word(CMD_FREE, FRAME_W'($urandom_range(MAX_FRAMES - 1)));
        end else if (pick < 96) begin
          send_word(CMD_NONE, FRAME_W'($urandom_range(MAX_FRAMES - 1)));
        end else begin
          send_word(CMD_INIT, FRAME_W'($urandom_range(MAX_FRAMES - 1)));
          high_water = (reserve_pick > managed) ? managed : reserve_pick;
        end
      end
    end

    wait_idle();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0 && results_owed == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
